@@ design/fdfc_pkg.sv @@
// fdfc_pkg: item types, constants, the byte-wise crc step and the ones'-complement
// add shared by the dual frame check sequence checker; no dependencies
package fdfc_pkg;

  localparam int unsigned CounterBitsDefault = 32;
  localparam int unsigned QueueDepthDefault  = 2;

  localparam logic [15:0] CrcPoly = 16'h8005;
  localparam logic [15:0] CrcMsb  = 16'h8000;
  localparam logic [15:0] AllOnes = 16'hFFFF;

  typedef struct packed {
    logic [7:0]  data_byte;
    logic        last_byte;
    logic [15:0] stored_checksum;
    logic [15:0] carried_crc;
  } in_item_t;

  typedef struct packed {
    logic [15:0] computed_checksum;
    logic [15:0] computed_crc;
    logic        checksum_ok;
    logic        crc_ok;
    logic        checksum_missed;
    logic [31:0] frames_seen;
    logic [31:0] checksum_accepts;
    logic [31:0] checksum_rejects;
    logic [31:0] crc_accepts;
    logic [31:0] crc_rejects;
  } out_item_t;

  // per-frame summary handed from front to back
  typedef struct packed {
    logic [15:0] computed_checksum;
    logic [15:0] computed_crc;
    logic [15:0] stored_checksum;
    logic [15:0] carried_crc;
  } frame_t;

  // msb-first crc-16 over one byte, eight shift steps
  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      if ((c & CrcMsb) != 16'h0000) begin
        c = {c[14:0], 1'b0} ^ CrcPoly;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

  // ones'-complement add with end-around carry
  function automatic logic [15:0] oc_add(input logic [15:0] acc, input logic [15:0] word);
    logic [16:0] s;
    logic [16:0] f;
    s = {1'b0, acc} + {1'b0, word};
    f = {1'b0, s[15:0]} + {16'h0000, s[16]};
    return f[15:0];
  endfunction

endpackage

@@ design/fdfc_front.sv @@
// fdfc_front: takes frame bytes, keeps the running checksum and crc, and
// posts one frame summary per last byte; depends on fdfc_pkg
module fdfc_front import fdfc_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     take_i,
  input  in_item_t item_i,
  output logic     post_o,
  output frame_t   frame_o
);

  logic [15:0] sum_q, sum_d;
  logic [15:0] crc_q, crc_d;
  logic [7:0]  high_q, high_d;
  logic        odd_q, odd_d;
  logic [15:0] word;
  logic [15:0] sum_new;
  logic [15:0] crc_new;

  always_comb begin
    crc_new = crc_byte(crc_q, item_i.data_byte);
    if (odd_q) begin
      word = {high_q, item_i.data_byte};
    end else begin
      word = {item_i.data_byte, 8'h00};
    end
    sum_new = oc_add(sum_q, word);

    sum_d  = sum_q;
    crc_d  = crc_q;
    high_d = high_q;
    odd_d  = odd_q;
    if (take_i) begin
      crc_d = crc_new;
      if (odd_q || item_i.last_byte) begin
        sum_d = sum_new;
        odd_d = 1'b0;
      end else begin
        high_d = item_i.data_byte;
        odd_d  = 1'b1;
      end
      if (item_i.last_byte) begin
        sum_d  = 16'h0000;
        crc_d  = 16'h0000;
        high_d = 8'h00;
        odd_d  = 1'b0;
      end
    end
  end

  assign post_o                    = take_i && item_i.last_byte;
  assign frame_o.computed_checksum = sum_new ^ AllOnes;
  assign frame_o.computed_crc      = crc_new;
  assign frame_o.stored_checksum   = item_i.stored_checksum;
  assign frame_o.carried_crc       = item_i.carried_crc;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q  <= 16'h0000;
      crc_q  <= 16'h0000;
      high_q <= 8'h00;
      odd_q  <= 1'b0;
    end else begin
      sum_q  <= sum_d;
      crc_q  <= crc_d;
      high_q <= high_d;
      odd_q  <= odd_d;
    end
  end

endmodule

@@ design/fdfc_queue.sv @@
// fdfc_queue: short queue of frame summaries between front and back
// depends on fdfc_pkg
module fdfc_queue import fdfc_pkg::*; #(
  parameter int unsigned DEPTH = QueueDepthDefault
) (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   wr_i,
  input  frame_t wr_data_i,
  output logic   full_o,
  input  logic   rd_i,
  output logic   valid_o,
  output frame_t rd_data_o
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(DEPTH);

  frame_t          mem_q [DEPTH];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_wr, do_rd;

  assign full_o    = (cnt_q == FullCnt);
  assign valid_o   = (cnt_q != '0);
  assign rd_data_o = mem_q[rd_ptr_q];
  assign do_wr     = wr_i && !full_o;
  assign do_rd     = rd_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_wr) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_rd) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_wr && !do_rd) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_rd && !do_wr) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

endmodule

@@ design/fdfc_back.sv @@
// fdfc_back: compares computed against stored values, keeps the saturating
// frame counters and holds the result register; depends on fdfc_pkg
module fdfc_back import fdfc_pkg::*; #(
  parameter int unsigned COUNTER_BITS = CounterBitsDefault
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      frame_valid_i,
  input  frame_t    frame_i,
  output logic      frame_take_o,
  input  logic      pop_i,
  output logic      empty_o,
  output out_item_t item_o
);

  localparam int unsigned WideW = (COUNTER_BITS > 32) ? COUNTER_BITS : 32;
  localparam logic [COUNTER_BITS-1:0] CntMax = '1;

  logic [COUNTER_BITS-1:0] frames_q, frames_d;
  logic [COUNTER_BITS-1:0] cs_acc_q, cs_acc_d;
  logic [COUNTER_BITS-1:0] cs_rej_q, cs_rej_d;
  logic [COUNTER_BITS-1:0] crc_acc_q, crc_acc_d;
  logic [COUNTER_BITS-1:0] crc_rej_q, crc_rej_d;
  logic [WideW-1:0]        frames_w, cs_acc_w, cs_rej_w, crc_acc_w, crc_rej_w;
  logic                    valid_q, valid_d;
  out_item_t               out_q, out_d;
  logic                    cs_ok, crc_ok;

  function automatic logic [COUNTER_BITS-1:0] sat_inc(input logic [COUNTER_BITS-1:0] c);
    return (c == CntMax) ? c : c + 1'b1;
  endfunction

  assign frame_take_o = frame_valid_i && (!valid_q || pop_i);
  assign empty_o      = !valid_q;
  assign item_o       = out_q;

  assign cs_ok  = (frame_i.computed_checksum == frame_i.stored_checksum);
  assign crc_ok = (frame_i.computed_crc == frame_i.carried_crc);

  always_comb begin
    frames_d  = frames_q;
    cs_acc_d  = cs_acc_q;
    cs_rej_d  = cs_rej_q;
    crc_acc_d = crc_acc_q;
    crc_rej_d = crc_rej_q;
    if (frame_take_o) begin
      frames_d = sat_inc(frames_q);
      if (cs_ok) begin
        cs_acc_d = sat_inc(cs_acc_q);
      end else begin
        cs_rej_d = sat_inc(cs_rej_q);
      end
      if (crc_ok) begin
        crc_acc_d = sat_inc(crc_acc_q);
      end else begin
        crc_rej_d = sat_inc(crc_rej_q);
      end
    end

    frames_w  = WideW'(frames_d);
    cs_acc_w  = WideW'(cs_acc_d);
    cs_rej_w  = WideW'(cs_rej_d);
    crc_acc_w = WideW'(crc_acc_d);
    crc_rej_w = WideW'(crc_rej_d);

    out_d.computed_checksum = frame_i.computed_checksum;
    out_d.computed_crc      = frame_i.computed_crc;
    out_d.checksum_ok       = cs_ok;
    out_d.crc_ok            = crc_ok;
    out_d.checksum_missed   = cs_ok && !crc_ok;
    out_d.frames_seen       = frames_w[31:0];
    out_d.checksum_accepts  = cs_acc_w[31:0];
    out_d.checksum_rejects  = cs_rej_w[31:0];
    out_d.crc_accepts       = crc_acc_w[31:0];
    out_d.crc_rejects       = crc_rej_w[31:0];

    valid_d = valid_q;
    if (frame_take_o) begin
      valid_d = 1'b1;
    end else if (pop_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (frame_take_o) begin
      out_q <= out_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frames_q  <= '0;
      cs_acc_q  <= '0;
      cs_rej_q  <= '0;
      crc_acc_q <= '0;
      crc_rej_q <= '0;
      valid_q   <= 1'b0;
    end else begin
      frames_q  <= frames_d;
      cs_acc_q  <= cs_acc_d;
      cs_rej_q  <= cs_rej_d;
      crc_acc_q <= crc_acc_d;
      crc_rej_q <= crc_rej_d;
      valid_q   <= valid_d;
    end
  end

endmodule

@@ design/frame_dual_fcs_checker_top.sv @@
// frame_dual_fcs_checker_top: dual frame check (ones'-complement checksum
// and crc-16) over a byte stream; depends on fdfc_pkg, fdfc_front,
// fdfc_queue and fdfc_back
//
//   channel   direction  handshake           payload
//   input     in         push / full         in_item_i  (in_item_t)
//   result    out        empty / pop         out_item_o (out_item_t)
//
// one byte item is taken per cycle while the summary queue has room, set by
// the one-byte crc step and checksum fold; a frame result reaches the result
// ports by way of the summary queue, written when its last byte is taken,
// and then the result register, loaded once the back is free to take it
// reset clears sums, counters, queue pointers and the result flag at once
// a held result stalls only the back; bytes keep flowing until the summary
// queue fills, and then full stays high until the back frees a slot
module frame_dual_fcs_checker_top import fdfc_pkg::*; #(
  parameter int unsigned COUNTER_BITS = CounterBitsDefault,
  parameter int unsigned QUEUE_DEPTH  = QueueDepthDefault
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push,
  output logic      full,
  input  in_item_t  in_item_i,
  output logic      empty,
  input  logic      pop,
  output out_item_t out_item_o
);

  logic   take;
  logic   post;
  frame_t post_frame;
  logic   q_full;
  logic   q_valid;
  logic   q_take;
  frame_t q_frame;

  // bytes are held off whenever the summary queue has no room
  assign full = q_full;
  assign take = push && !q_full;

  fdfc_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .take_i  (take),
    .item_i  (in_item_i),
    .post_o  (post),
    .frame_o (post_frame)
  );

  fdfc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_i      (post),
    .wr_data_i (post_frame),
    .full_o    (q_full),
    .rd_i      (q_take),
    .valid_o   (q_valid),
    .rd_data_o (q_frame)
  );

  // compare, count and hold the result item
  fdfc_back #(
    .COUNTER_BITS (COUNTER_BITS)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .frame_valid_i (q_valid),
    .frame_i       (q_frame),
    .frame_take_o  (q_take),
    .pop_i         (pop),
    .empty_o       (empty),
    .item_o        (out_item_o)
  );

endmodule

@@ tb/tb.sv @@
// tb: self-checking bench for frame_dual_fcs_checker_top, frames of random bytes
// checked against a behavioral checksum/crc predictor with random idling on both sides
// depends on fdfc_pkg (item types) and the design under test
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import fdfc_pkg::*;

  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int TOTAL_ITEMS  = 1150;
  localparam int DRAIN_CYCLES = 20;

  // how the stored checksum and crc of the last byte relate to the computed ones
  typedef enum logic [2:0] {
    STORE_BOTH_OK,
    STORE_CS_ONLY,
    STORE_CRC_ONLY,
    STORE_NONE_OK,
    STORE_RANDOM
  } store_mode_e;

  logic      clk_i;
  logic      rst_ni = 1'b0;
  logic      push = 1'b0;
  logic      full;
  in_item_t  in_item_i = '0;
  logic      empty;
  logic      pop = 1'b0;
  out_item_t out_item_o;

  // predictor state, one copy of what the block keeps per frame and overall
  logic [15:0] sum_acc;
  logic [7:0]  high_byte;
  logic        odd_pos;
  logic [15:0] crc_acc;
  logic [31:0] cnt_frames;
  logic [31:0] cnt_cs_ok;
  logic [31:0] cnt_cs_bad;
  logic [31:0] cnt_crc_ok;
  logic [31:0] cnt_crc_bad;

  out_item_t   frame_results_q[$];
  out_item_t   want_res;
  logic [7:0]  frame_bytes[$];

  int unsigned cycle_cnt    = 0;
  int unsigned mismatch_cnt = 0;
  int unsigned items_sent   = 0;
  int          pop_stall    = 0;

  frame_dual_fcs_checker_top dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push       (push),
    .full       (full),
    .in_item_i  (in_item_i),
    .empty      (empty),
    .pop        (pop),
    .out_item_o (out_item_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // cycle counter doubles as the watchdog
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // msb-first crc-16, poly 0x8005, one byte
  function automatic logic [15:0] crc16_step(logic [15:0] c, logic [7:0] b);
    logic [15:0] r;
    r = c ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      r = r[15] ? ({r[14:0], 1'b0} ^ CrcPoly) : {r[14:0], 1'b0};
    end
    return r;
  endfunction

  // 16-bit add with the carry wrapped back into bit 0
  function automatic logic [15:0] fold_add(logic [15:0] a, logic [15:0] w);
    logic [16:0] s;
    s = {1'b0, a} + {1'b0, w};
    return s[15:0] + {15'd0, s[16]};
  endfunction

  // counters stick at all ones; out of reach for a run this long
  function automatic logic [31:0] sat_inc(logic [31:0] c);
    return (c == 32'hFFFF_FFFF) ? c : c + 32'd1;
  endfunction

  // gap length for either side: mostly none, some short, a few long,
  // and a recurring quiet window with no idling at all
  function automatic int pick_gap();
    int r;
    if ((cycle_cnt % 600) < 80) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic void fcs_clear_frame();
    sum_acc   = '0;
    high_byte = '0;
    odd_pos   = 1'b0;
    crc_acc   = '0;
  endfunction

  // absorb one accepted byte; on the last byte queue the frame result
  function automatic void fcs_predict(in_item_t it);
    out_item_t res;
    crc_acc = crc16_step(crc_acc, it.data_byte);
    if (odd_pos) begin
      sum_acc = fold_add(sum_acc, {high_byte, it.data_byte});
      odd_pos = 1'b0;
    end else if (it.last_byte) begin
      // odd byte count: pad the final byte with a zero low byte
      sum_acc = fold_add(sum_acc, {it.data_byte, 8'h00});
    end else begin
      high_byte = it.data_byte;
      odd_pos   = 1'b1;
    end
    if (it.last_byte) begin
      res.computed_checksum = ~sum_acc;
      res.computed_crc      = crc_acc;
      res.checksum_ok       = (res.computed_checksum == it.stored_checksum);
      res.crc_ok            = (res.computed_crc == it.carried_crc);
      res.checksum_missed   = res.checksum_ok && !res.crc_ok;
      cnt_frames = sat_inc(cnt_frames);
      if (res.checksum_ok) cnt_cs_ok = sat_inc(cnt_cs_ok);
      else cnt_cs_bad = sat_inc(cnt_cs_bad);
      if (res.crc_ok) cnt_crc_ok = sat_inc(cnt_crc_ok);
      else cnt_crc_bad = sat_inc(cnt_crc_bad);
      res.frames_seen      = cnt_frames;
      res.checksum_accepts = cnt_cs_ok;
      res.checksum_rejects = cnt_cs_bad;
      res.crc_accepts      = cnt_crc_ok;
      res.crc_rejects      = cnt_crc_bad;
      frame_results_q.push_back(res);
      fcs_clear_frame();
    end
  endfunction

  // one item through the push/full handshake; push stays high when the
  // next item follows with no gap
  task automatic send_item(input in_item_t it);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    push      <= 1'b1;
    in_item_i <= it;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    fcs_predict(it);
    items_sent++;
  endtask

  // send frame_bytes as one frame; stored fields on the last byte follow mode,
  // on other bytes they are noise the block must ignore
  task automatic send_frame(input store_mode_e mode);
    in_item_t    it;
    logic [15:0] cs_next;
    logic [15:0] crc_next;
    for (int i = 0; i < frame_bytes.size(); i++) begin
      it.data_byte       = frame_bytes[i];
      it.last_byte       = (i == frame_bytes.size() - 1);
      it.stored_checksum = 16'($urandom);
      it.carried_crc     = 16'($urandom);
      if (it.last_byte) begin
        // look ahead at what the frame will compute with this byte
        crc_next = crc16_step(crc_acc, it.data_byte);
        cs_next  = odd_pos ? ~fold_add(sum_acc, {high_byte, it.data_byte})
                           : ~fold_add(sum_acc, {it.data_byte, 8'h00});
        case (mode)
          STORE_BOTH_OK: begin
            it.stored_checksum = cs_next;
            it.carried_crc     = crc_next;
          end
          STORE_CS_ONLY: begin
            it.stored_checksum = cs_next;
            it.carried_crc     = crc_next ^ 16'($urandom_range(1, 65535));
          end
          STORE_CRC_ONLY: begin
            it.stored_checksum = cs_next ^ 16'($urandom_range(1, 65535));
            it.carried_crc     = crc_next;
          end
          STORE_NONE_OK: begin
            it.stored_checksum = cs_next ^ 16'($urandom_range(1, 65535));
            it.carried_crc     = crc_next ^ 16'($urandom_range(1, 65535));
          end
          default: begin
          end
        endcase
      end
      send_item(it);
    end
  endtask

  task automatic check_field(input string fname, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      mismatch_cnt++;
      if (mismatch_cnt <= 10)
        $display("mismatch %s: expected %h, got %h at cycle %0d", fname, want, got,
                 cycle_cnt);
    end
  endtask

  // result side: random pop stalls, each accepted result checked against
  // the oldest queued frame result
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        if (frame_results_q.size() == 0) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10)
            $display("unexpected result at cycle %0d: %h", cycle_cnt, out_item_o);
        end else begin
          want_res = frame_results_q.pop_front();
          check_field("computed_checksum", 32'(want_res.computed_checksum),
                      32'(out_item_o.computed_checksum));
          check_field("computed_crc", 32'(want_res.computed_crc),
                      32'(out_item_o.computed_crc));
          check_field("checksum_ok", 32'(want_res.checksum_ok), 32'(out_item_o.checksum_ok));
          check_field("crc_ok", 32'(want_res.crc_ok), 32'(out_item_o.crc_ok));
          check_field("checksum_missed", 32'(want_res.checksum_missed),
                      32'(out_item_o.checksum_missed));
          check_field("frames_seen", want_res.frames_seen, out_item_o.frames_seen);
          check_field("checksum_accepts", want_res.checksum_accepts,
                      out_item_o.checksum_accepts);
          check_field("checksum_rejects", want_res.checksum_rejects,
                      out_item_o.checksum_rejects);
          check_field("crc_accepts", want_res.crc_accepts, out_item_o.crc_accepts);
          check_field("crc_rejects", want_res.crc_rejects, out_item_o.crc_rejects);
        end
      end
      if (pop_stall > 0) begin
        pop <= 1'b0;
        pop_stall--;
      end else begin
        pop <= 1'b1;
        pop_stall = pick_gap();
      end
    end
  end

  // one-byte frames, each padded as a high byte
  task automatic test_single_byte_frames();
    frame_bytes = '{8'h00};
    send_frame(STORE_BOTH_OK);
    frame_bytes = '{8'hFF};
    send_frame(STORE_NONE_OK);
    frame_bytes = '{8'h80};
    send_frame(STORE_CRC_ONLY);
  endtask

  // every combination of checksum and crc outcome, odd and even lengths
  task automatic test_fcs_outcomes();
    frame_bytes = '{8'h12, 8'h34, 8'h56};
    send_frame(STORE_BOTH_OK);
    frame_bytes = '{8'hAB, 8'hCD};
    send_frame(STORE_CS_ONLY);
    frame_bytes = '{8'h01, 8'h02, 8'h03, 8'h04};
    send_frame(STORE_CRC_ONLY);
    frame_bytes = '{8'hFE, 8'hDC, 8'hBA};
    send_frame(STORE_NONE_OK);
  endtask

  // all-ones and all-zero frames: checksum 0x0000 and 0xFFFF, carry folds
  task automatic test_extreme_frames();
    frame_bytes = '{8'hFF, 8'hFF};
    send_frame(STORE_BOTH_OK);
    frame_bytes = '{8'h00, 8'h00};
    send_frame(STORE_BOTH_OK);
    frame_bytes = '{8'hFF, 8'hFF, 8'hFF};
    send_frame(STORE_RANDOM);
  endtask

  // random frames, mostly short, a few long, some of constant bytes
  task automatic test_random_frames();
    int r;
    int len;
    int flavor;
    while (items_sent < TOTAL_ITEMS) begin
      r = $urandom_range(0, 99);
      if (r < 70) len = $urandom_range(1, 8);
      else if (r < 95) len = $urandom_range(9, 24);
      else len = $urandom_range(25, 64);
      flavor = $urandom_range(0, 9);
      frame_bytes = {};
      for (int i = 0; i < len; i++) begin
        if (flavor == 0) frame_bytes.push_back(8'hFF);
        else if (flavor == 1) frame_bytes.push_back(8'h00);
        else frame_bytes.push_back(8'($urandom));
      end
      send_frame(store_mode_e'($urandom_range(0, 4)));
    end
  endtask

  initial begin
    cnt_frames  = '0;
    cnt_cs_ok   = '0;
    cnt_cs_bad  = '0;
    cnt_crc_ok  = '0;
    cnt_crc_bad = '0;
    fcs_clear_frame();

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_single_byte_frames();
    test_fcs_outcomes();
    test_extreme_frames();
    test_random_frames();
    push <= 1'b0;

    // drain: every expected frame result, then a last wait for strays
    while (frame_results_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (mismatch_cnt == 0 && frame_results_q.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
design/fdfc_pkg.sv
design/fdfc_front.sv
design/fdfc_queue.sv
design/fdfc_back.sv
design/frame_dual_fcs_checker_top.sv
tb/tb.sv
